FILE: rtl/ihsr_pkg.sv
package ihsr_pkg;

  // Field widths of the channel payloads.
  localparam int unsigned OpWidth     = 2;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned AddrWidth   = 7;
  localparam int unsigned ActionWidth = 3;
  localparam int unsigned TempWidth   = 15;
  localparam int unsigned HumWidth    = 14;
  localparam int unsigned RawWidth    = 16;

  // Sensor bus address after reset.
  localparam logic [AddrWidth-1:0] DefaultDeviceAddress = 7'd64;

  // Input item kinds.
  typedef enum logic [OpWidth-1:0] {
    OP_READ_TEMP = 2'd0,
    OP_READ_HUM  = 2'd1,
    OP_STATUS    = 2'd2
  } ihsr_op_e;

  // Bus actions requested from the two-wire controller.
  typedef enum logic [ActionWidth-1:0] {
    ACT_START   = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_RD_ACK  = 3'd2,
    ACT_RD_NACK = 3'd3,
    ACT_STOP    = 3'd4,
    ACT_NONE    = 3'd5
  } ihsr_action_e;

  // Sequencer steps: each one but idle waits for the status of the previous bus action.
  typedef enum logic [2:0] {
    STEP_IDLE    = 3'd0,
    STEP_START   = 3'd1,
    STEP_SLA_W   = 3'd2,
    STEP_CMD     = 3'd3,
    STEP_RESTART = 3'd4,
    STEP_SLA_R   = 3'd5,
    STEP_RD_ACK  = 3'd6,
    STEP_RD_NACK = 3'd7
  } ihsr_step_e;

  // Controller status codes (low three bits are don't-care).
  localparam logic [ByteWidth-1:0] StStart       = 8'h08;
  localparam logic [ByteWidth-1:0] StRepStart    = 8'h10;
  localparam logic [ByteWidth-1:0] StMtSlaAck    = 8'h18;
  localparam logic [ByteWidth-1:0] StMtDataAck   = 8'h28;
  localparam logic [ByteWidth-1:0] StMrSlaAck    = 8'h40;
  localparam logic [ByteWidth-1:0] StMrDataAck   = 8'h50;
  localparam logic [ByteWidth-1:0] StMrDataNack  = 8'h58;
  localparam logic [ByteWidth-1:0] StatusMask    = 8'hF8;

  // Sensor command bytes.
  localparam logic [ByteWidth-1:0] CmdHumidity    = 8'hE5;
  localparam logic [ByteWidth-1:0] CmdTempReuse   = 8'hE0;
  localparam logic [ByteWidth-1:0] CmdTempMeasure = 8'hE3;

  // Conversion constants; the two offsets are scaled by 2^16.
  localparam logic [14:0]          TempGain    = 15'd17572;
  localparam logic signed [31:0]   TempOffset  = 32'sd307036160;  // 4685 * 65536
  localparam logic [13:0]          HumGain     = 14'd12500;
  localparam logic [29:0]          HumOffset   = 30'd39321600;    // 600 * 65536
  localparam logic [RawWidth-1:0]  HumRawLimit = 16'hFFF0;
  localparam logic [HumWidth-1:0]  HumMax      = 14'd10000;

endpackage

FILE: rtl/ihsr_in_if.sv
interface ihsr_in_if;
  logic                           valid;
  logic                           ready;
  logic [ihsr_pkg::OpWidth-1:0]   op;
  logic [ihsr_pkg::ByteWidth-1:0] status_code;
  logic [ihsr_pkg::ByteWidth-1:0] data_byte;

  modport source (output valid, output op, output status_code, output data_byte,
                  input ready);
  modport sink (input valid, input op, input status_code, input data_byte,
                output ready);
endinterface

FILE: rtl/ihsr_out_if.sv
interface ihsr_out_if;
  logic                                valid;
  logic                                ready;
  logic [ihsr_pkg::ActionWidth-1:0]    bus_action;
  logic [ihsr_pkg::ByteWidth-1:0]      send_byte;
  logic                                done_res;
  logic                                success;
  logic                                is_humidity;
  logic signed [ihsr_pkg::TempWidth-1:0] temperature_centi;
  logic [ihsr_pkg::HumWidth-1:0]       humidity_centi;

  modport source (output valid, output bus_action, output send_byte, output done_res,
                  output success, output is_humidity, output temperature_centi,
                  output humidity_centi, input ready);
  modport sink (input valid, input bus_action, input send_byte, input done_res,
                input success, input is_humidity, input temperature_centi,
                input humidity_centi, output ready);
endinterface

FILE: rtl/ihsr_cfg_if.sv
interface ihsr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ihsr_pkg::AddrWidth-1:0] device_address;

  modport source (output valid, output device_address, input ready);
  modport sink (input valid, input device_address, output ready);
endinterface

FILE: rtl/i2c_humidity_sensor_reader.sv
// Channel   Direction  Payload
// cfg_i     in         device_address (7-bit sensor bus address)
// in_i      in         op, status_code, data_byte
// out_o     out        bus_action, send_byte, done_res, success, is_humidity,
//                      temperature_centi, humidity_centi
//
// Every accepted transaction gives exactly one result transaction, through the input
// register feeding the step logic and then the result register. One transaction is
// taken per cycle while out_o is not stalled.
// Reset (rst_ni low) returns the sequencer to idle and the address to 64.
// A stall on out_o holds the result register and then the input register, and
// in_i.ready drops only when both are full.
module i2c_humidity_sensor_reader (
  input  logic       clk_i,
  input  logic       rst_ni,
  ihsr_cfg_if.sink   cfg_i,
  ihsr_in_if.sink    in_i,
  ihsr_out_if.source out_o
);

  // Configuration register.
  logic [ihsr_pkg::AddrWidth-1:0] dev_addr_q;

  // Input register stage.
  logic                           in_vld_q;
  logic [ihsr_pkg::OpWidth-1:0]   in_op_q;
  logic [ihsr_pkg::ByteWidth-1:0] in_status_q;
  logic [ihsr_pkg::ByteWidth-1:0] in_data_q;

  // Sequencer state.
  ihsr_pkg::ihsr_step_e           step_q, step_d;
  logic                           rd_hum_q, rd_hum_d;
  logic [ihsr_pkg::ByteWidth-1:0] raw_hi_q, raw_hi_d;
  logic                           hum_valid_q, hum_valid_d;

  // Result register stage.
  logic                                  out_vld_q;
  ihsr_pkg::ihsr_action_e                act_q, act_d;
  logic [ihsr_pkg::ByteWidth-1:0]        sbyte_q, sbyte_d;
  logic                                  done_q, done_d;
  logic                                  ok_q, ok_d;
  logic                                  ishum_q, ishum_d;
  logic signed [ihsr_pkg::TempWidth-1:0] temp_q, temp_d;
  logic [ihsr_pkg::HumWidth-1:0]         hum_q, hum_d;

  // Handshake and step decode.
  logic                           out_free;
  logic                           fire;
  logic                           is_cmd;
  logic                           is_status;
  logic                           good;
  logic [ihsr_pkg::ByteWidth-1:0] st;
  logic [ihsr_pkg::ByteWidth-1:0] sla;

  // Conversion datapath.
  logic [ihsr_pkg::RawWidth-1:0]  raw;
  logic [30:0]                    temp_prod;
  logic signed [31:0]             temp_num;
  logic signed [15:0]             temp_trunc;
  logic [29:0]                    hum_prod;
  logic [29:0]                    hum_diff;
  logic [ihsr_pkg::HumWidth-1:0]  hum_val;

  // The result register frees up when empty or when its transaction completes.
  assign out_free   = !out_vld_q || out_o.ready;
  assign fire       = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || out_free;
  assign cfg_i.ready = 1'b1;

  assign is_cmd    = (in_op_q == ihsr_pkg::OP_READ_TEMP) ||
                     (in_op_q == ihsr_pkg::OP_READ_HUM);
  assign is_status = (in_op_q == ihsr_pkg::OP_STATUS) && (step_q != ihsr_pkg::STEP_IDLE);
  assign st        = in_status_q & ihsr_pkg::StatusMask;
  assign sla       = {dev_addr_q, 1'b0};
  assign raw       = {raw_hi_q, in_data_q};

  // Expected status for the step that is waiting.
  always_comb begin
    case (step_q)
      ihsr_pkg::STEP_START:   good = (st == ihsr_pkg::StStart) ||
                                     (st == ihsr_pkg::StRepStart);
      ihsr_pkg::STEP_SLA_W:   good = (st == ihsr_pkg::StMtSlaAck);
      ihsr_pkg::STEP_CMD:     good = (st == ihsr_pkg::StMtDataAck);
      ihsr_pkg::STEP_RESTART: good = (st == ihsr_pkg::StRepStart);
      ihsr_pkg::STEP_SLA_R:   good = (st == ihsr_pkg::StMrSlaAck);
      ihsr_pkg::STEP_RD_ACK:  good = (st == ihsr_pkg::StMrDataAck);
      ihsr_pkg::STEP_RD_NACK: good = (st == ihsr_pkg::StMrDataNack);
      default:                good = 1'b0;
    endcase
  end

  // Temperature: raw * 17572 / 65536 - 4685, truncated toward zero.
  assign temp_prod  = 31'(raw) * 31'(ihsr_pkg::TempGain);
  assign temp_num   = $signed({1'b0, temp_prod}) - ihsr_pkg::TempOffset;
  assign temp_trunc = temp_num[31:16] + 16'((temp_num[31] && (temp_num[15:0] != '0)) ? 1 : 0);

  // Humidity: (raw * 12500 - 600 * 65536) / 65536, clamped to 0..10000.
  assign hum_prod = 30'(raw) * 30'(ihsr_pkg::HumGain);
  assign hum_diff = hum_prod - ihsr_pkg::HumOffset;
  always_comb begin
    if (raw >= ihsr_pkg::HumRawLimit) begin
      hum_val = ihsr_pkg::HumMax;
    end else if (hum_prod < ihsr_pkg::HumOffset) begin
      hum_val = '0;
    end else if (hum_diff[29:16] > ihsr_pkg::HumMax) begin
      hum_val = ihsr_pkg::HumMax;
    end else begin
      hum_val = hum_diff[29:16];
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    step_d      = step_q;
    rd_hum_d    = rd_hum_q;
    raw_hi_d    = raw_hi_q;
    hum_valid_d = hum_valid_q;
    if (is_cmd && (step_q == ihsr_pkg::STEP_IDLE)) begin
      rd_hum_d = in_op_q[0];
      step_d   = ihsr_pkg::STEP_START;
    end else if (is_status) begin
      if (!good) begin
        step_d = ihsr_pkg::STEP_IDLE;
        if (rd_hum_q) begin
          hum_valid_d = 1'b0;
        end
      end else begin
        case (step_q)
          ihsr_pkg::STEP_START:   step_d = ihsr_pkg::STEP_SLA_W;
          ihsr_pkg::STEP_SLA_W:   step_d = ihsr_pkg::STEP_CMD;
          ihsr_pkg::STEP_CMD:     step_d = ihsr_pkg::STEP_RESTART;
          ihsr_pkg::STEP_RESTART: step_d = ihsr_pkg::STEP_SLA_R;
          ihsr_pkg::STEP_SLA_R:   step_d = ihsr_pkg::STEP_RD_ACK;
          ihsr_pkg::STEP_RD_ACK: begin
            raw_hi_d = in_data_q;
            step_d   = ihsr_pkg::STEP_RD_NACK;
          end
          default: begin
            step_d = ihsr_pkg::STEP_IDLE;
            if (rd_hum_q) begin
              hum_valid_d = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Output logic: the result of the transaction held in the input register.
  always_comb begin
    act_d   = ihsr_pkg::ACT_NONE;
    sbyte_d = '0;
    done_d  = 1'b0;
    ok_d    = 1'b0;
    ishum_d = 1'b0;
    temp_d  = '0;
    hum_d   = '0;
    if (is_cmd && (step_q == ihsr_pkg::STEP_IDLE)) begin
      act_d = ihsr_pkg::ACT_START;
    end else if (is_status) begin
      if (!good) begin
        // A failed first start never owned the bus, so no stop follows.
        act_d   = (step_q == ihsr_pkg::STEP_START) ? ihsr_pkg::ACT_NONE
                                                  : ihsr_pkg::ACT_STOP;
        done_d  = 1'b1;
        ishum_d = rd_hum_q;
      end else begin
        case (step_q)
          ihsr_pkg::STEP_START: begin
            act_d   = ihsr_pkg::ACT_SEND;
            sbyte_d = sla;
          end
          ihsr_pkg::STEP_SLA_W: begin
            act_d   = ihsr_pkg::ACT_SEND;
            sbyte_d = rd_hum_q    ? ihsr_pkg::CmdHumidity :
                      hum_valid_q ? ihsr_pkg::CmdTempReuse : ihsr_pkg::CmdTempMeasure;
          end
          ihsr_pkg::STEP_CMD:     act_d = ihsr_pkg::ACT_START;
          ihsr_pkg::STEP_RESTART: begin
            act_d   = ihsr_pkg::ACT_SEND;
            sbyte_d = sla | 8'h01;
          end
          ihsr_pkg::STEP_SLA_R:   act_d = ihsr_pkg::ACT_RD_ACK;
          ihsr_pkg::STEP_RD_ACK:  act_d = ihsr_pkg::ACT_RD_NACK;
          default: begin
            act_d   = ihsr_pkg::ACT_STOP;
            done_d  = 1'b1;
            ok_d    = 1'b1;
            ishum_d = rd_hum_q;
            if (rd_hum_q) begin
              hum_d = hum_val;
            end else begin
              temp_d = temp_trunc[ihsr_pkg::TempWidth-1:0];
            end
          end
        endcase
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= ihsr_pkg::DefaultDeviceAddress;
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      step_q      <= ihsr_pkg::STEP_IDLE;
      rd_hum_q    <= 1'b0;
      raw_hi_q    <= '0;
      hum_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        dev_addr_q <= cfg_i.device_address;
      end
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
      if (fire) begin
        step_q      <= step_d;
        rd_hum_q    <= rd_hum_d;
        raw_hi_q    <= raw_hi_d;
        hum_valid_q <= hum_valid_d;
      end
    end
  end

  // Payload registers of both stages.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_op_q     <= in_i.op;
      in_status_q <= in_i.status_code;
      in_data_q   <= in_i.data_byte;
    end
    if (fire) begin
      act_q   <= act_d;
      sbyte_q <= sbyte_d;
      done_q  <= done_d;
      ok_q    <= ok_d;
      ishum_q <= ishum_d;
      temp_q  <= temp_d;
      hum_q   <= hum_d;
    end
  end

  // Result channel.
  assign out_o.valid             = out_vld_q;
  assign out_o.bus_action        = act_q;
  assign out_o.send_byte         = sbyte_q;
  assign out_o.done_res          = done_q;
  assign out_o.success           = ok_q;
  assign out_o.is_humidity       = ishum_q;
  assign out_o.temperature_centi = temp_q;
  assign out_o.humidity_centi    = hum_q;

endmodule

FILE: tb/ihsr_reply_check.sv
// Watches the configuration, command/status and bus action channels of the
// humidity sensor reader, predicts each bus action and compares it.
module ihsr_reply_check
  import ihsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ihsr_cfg_if         cfg_mon_i,
  ihsr_in_if          in_mon_i,
  ihsr_out_if         out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted bus action transaction.
  typedef struct packed {
    ihsr_action_e                bus_action;
    logic [ByteWidth-1:0]        send_byte;
    logic                        done_res;
    logic                        success;
    logic                        is_humidity;
    logic signed [TempWidth-1:0] temperature_centi;
    logic [HumWidth-1:0]         humidity_centi;
  } bus_reply_t;

  // Predicted sequencer state.
  logic [AddrWidth-1:0] sensor_addr;
  ihsr_step_e           seq_step;
  logic                 hum_kind;
  logic [ByteWidth-1:0] high_byte;
  logic                 hum_fresh;

  bus_reply_t  reply_q[$];
  int unsigned fails = 0;
  int unsigned pending_n = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending_n;

  // Raw reading to hundredths of a degree, truncated toward zero.
  function automatic logic signed [TempWidth-1:0] raw_to_temp(logic [RawWidth-1:0] raw);
    longint num;
    num = longint'(raw) * longint'(TempGain) - longint'(TempOffset);
    return TempWidth'(num / 65536);
  endfunction

  // Raw reading to hundredths of a percent, saturated to 0..100 percent.
  function automatic logic [HumWidth-1:0] raw_to_hum(logic [RawWidth-1:0] raw);
    longint num;
    longint q;
    if (raw >= HumRawLimit) begin
      return HumMax;
    end
    num = longint'(raw) * longint'(HumGain) - longint'(HumOffset);
    if (num < 0) begin
      return '0;
    end
    q = num / 65536;
    if (q > longint'(HumMax)) begin
      q = longint'(HumMax);
    end
    return HumWidth'(q);
  endfunction

  // Advances the sequencer by one accepted transaction and returns its answer.
  function automatic bus_reply_t advance_sequencer(logic [OpWidth-1:0] op,
                                                   logic [ByteWidth-1:0] status_code,
                                                   logic [ByteWidth-1:0] data_byte);
    bus_reply_t           r;
    logic [ByteWidth-1:0] st;
    logic [ByteWidth-1:0] sla;
    logic                 good;
    r = '0;
    r.bus_action = ACT_NONE;
    st = status_code & StatusMask;
    sla = {sensor_addr, 1'b0};
    if (op == OP_READ_TEMP || op == OP_READ_HUM) begin
      if (seq_step == STEP_IDLE) begin
        hum_kind = (op == OP_READ_HUM);
        r.bus_action = ACT_START;
        seq_step = STEP_START;
      end
    end else if (op == OP_STATUS && seq_step != STEP_IDLE) begin
      case (seq_step)
        STEP_START:   good = (st == StStart || st == StRepStart);
        STEP_SLA_W:   good = (st == StMtSlaAck);
        STEP_CMD:     good = (st == StMtDataAck);
        STEP_RESTART: good = (st == StRepStart);
        STEP_SLA_R:   good = (st == StMrSlaAck);
        STEP_RD_ACK:  good = (st == StMrDataAck);
        default:      good = (st == StMrDataNack);
      endcase
      if (!good) begin
        // A failed first start has no bus to release, so no stop follows.
        r.bus_action = (seq_step == STEP_START) ? ACT_NONE : ACT_STOP;
        r.done_res = 1'b1;
        r.is_humidity = hum_kind;
        if (hum_kind) begin
          hum_fresh = 1'b0;
        end
        seq_step = STEP_IDLE;
      end else begin
        case (seq_step)
          STEP_START: begin
            r.bus_action = ACT_SEND;
            r.send_byte = sla;
            seq_step = STEP_SLA_W;
          end
          STEP_SLA_W: begin
            r.bus_action = ACT_SEND;
            r.send_byte = hum_kind ? CmdHumidity : (hum_fresh ? CmdTempReuse : CmdTempMeasure);
            seq_step = STEP_CMD;
          end
          STEP_CMD: begin
            r.bus_action = ACT_START;
            seq_step = STEP_RESTART;
          end
          STEP_RESTART: begin
            r.bus_action = ACT_SEND;
            r.send_byte = sla | 8'h01;
            seq_step = STEP_SLA_R;
          end
          STEP_SLA_R: begin
            r.bus_action = ACT_RD_ACK;
            seq_step = STEP_RD_ACK;
          end
          STEP_RD_ACK: begin
            high_byte = data_byte;
            r.bus_action = ACT_RD_NACK;
            seq_step = STEP_RD_NACK;
          end
          default: begin
            r.bus_action = ACT_STOP;
            r.done_res = 1'b1;
            r.success = 1'b1;
            r.is_humidity = hum_kind;
            if (hum_kind) begin
              r.humidity_centi = raw_to_hum({high_byte, data_byte});
              hum_fresh = 1'b1;
            end else begin
              r.temperature_centi = raw_to_temp({high_byte, data_byte});
            end
            seq_step = STEP_IDLE;
          end
        endcase
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic signed [31:0] expv, logic signed [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, actual %0d", name, expv, actv);
      fails++;
    end
  endtask

  // Follow every transaction on the three channels.
  always @(posedge clk_i or negedge rst_ni) begin
    bus_reply_t exp_r;
    if (!rst_ni) begin
      sensor_addr = DefaultDeviceAddress;
      seq_step = STEP_IDLE;
      hum_kind = 1'b0;
      high_byte = '0;
      hum_fresh = 1'b0;
      reply_q.delete();
      pending_n = 0;
    end else begin
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        sensor_addr = cfg_mon_i.device_address;
      end
      if (out_mon_i.valid === 1'b1 && out_mon_i.ready) begin
        if (reply_q.size() == 0) begin
          $error("bus action transaction with no prediction waiting");
          fails++;
        end else begin
          exp_r = reply_q.pop_front();
          check_field("bus_action", 32'(exp_r.bus_action), 32'(out_mon_i.bus_action));
          check_field("send_byte", 32'(exp_r.send_byte), 32'(out_mon_i.send_byte));
          check_field("done_res", 32'(exp_r.done_res), 32'(out_mon_i.done_res));
          check_field("success", 32'(exp_r.success), 32'(out_mon_i.success));
          check_field("is_humidity", 32'(exp_r.is_humidity), 32'(out_mon_i.is_humidity));
          check_field("temperature_centi", 32'(exp_r.temperature_centi),
                      32'(out_mon_i.temperature_centi));
          check_field("humidity_centi", 32'(exp_r.humidity_centi),
                      32'(out_mon_i.humidity_centi));
        end
      end
      if (in_mon_i.valid && in_mon_i.ready === 1'b1) begin
        reply_q.push_back(advance_sequencer(in_mon_i.op, in_mon_i.status_code,
                                            in_mon_i.data_byte));
      end
      pending_n = reply_q.size();
    end
  end

endmodule

FILE: tb/tb.sv
// Drives commands and bus status events into the humidity sensor reader with
// random gaps and output stalls, and reports the verdict from the checker.
module tb;
  import ihsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Op code that the block must ignore, and a status that no step accepts.
  localparam logic [OpWidth-1:0]   OpUnused = 2'd3;
  localparam logic [ByteWidth-1:0] StBogus  = 8'hFF;
  localparam int unsigned          NumItems = 900;

  logic clk_i;
  logic rst_ni;

  ihsr_cfg_if cfg_if ();
  ihsr_in_if  in_if ();
  ihsr_out_if out_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent = 0;
  bit          quiet_phase = 1'b0;

  i2c_humidity_sensor_reader dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  ihsr_reply_check u_reply_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon_i    (cfg_if),
    .in_mon_i     (in_if),
    .out_mon_i    (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Mostly short gaps, now and then a long one; none in a quiet phase.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_phase) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Received bytes lean toward the extremes now and then.
  function automatic logic [ByteWidth-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 8'h00;
    end else if (r == 1) begin
      return 8'hFF;
    end
    return ByteWidth'($urandom_range(0, 255));
  endfunction

  // Receiver side: random stalls between runs of ready.
  initial begin
    int unsigned stall_cnt;
    int unsigned run_cnt;
    stall_cnt = 0;
    run_cnt = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (run_cnt == 0) begin
        run_cnt = $urandom_range(1, 12);
        stall_cnt = pick_gap();
      end
      if (stall_cnt > 0) begin
        out_if.ready <= 1'b0;
        stall_cnt--;
      end else begin
        out_if.ready <= 1'b1;
        run_cnt--;
      end
    end
  end

  // One input transaction, after a random gap.
  task automatic send_item(logic [OpWidth-1:0] op, logic [ByteWidth-1:0] st,
                           logic [ByteWidth-1:0] data);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.status_code <= st;
    in_if.data_byte <= data;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_status(logic [ByteWidth-1:0] st, logic [ByteWidth-1:0] data);
    send_item(OP_STATUS, st, data);
  endtask

  // Stop sending and wait until every predicted bus action has come out.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_address(logic [AddrWidth-1:0] addr);
    cfg_if.valid <= 1'b1;
    cfg_if.device_address <= addr;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // A command and its status events, with random content, an occasional
  // abort and an occasional stray item in the middle.
  task automatic run_read();
    logic [ByteWidth-1:0] good_st[7];
    logic [ByteWidth-1:0] st;
    logic [OpWidth-1:0]   stray_op;
    good_st[0] = $urandom_range(0, 1) ? StStart : StRepStart;
    good_st[1] = StMtSlaAck;
    good_st[2] = StMtDataAck;
    good_st[3] = StRepStart;
    good_st[4] = StMrSlaAck;
    good_st[5] = StMrDataAck;
    good_st[6] = StMrDataNack;
    send_item($urandom_range(0, 1) ? OP_READ_HUM : OP_READ_TEMP,
              ByteWidth'($urandom_range(0, 255)), ByteWidth'($urandom_range(0, 255)));
    for (int s = 0; s < 7; s++) begin
      if ($urandom_range(0, 19) == 0) begin
        stray_op = $urandom_range(0, 1) ? OpUnused : OpWidth'($urandom_range(0, 1));
        send_item(stray_op, ByteWidth'($urandom_range(0, 255)),
                  ByteWidth'($urandom_range(0, 255)));
      end
      st = good_st[s] | ByteWidth'($urandom_range(0, 7));
      if ($urandom_range(0, 11) == 0) begin
        send_status(st ^ 8'h80, pick_byte());
        return;
      end
      send_status(st, pick_byte());
    end
  endtask

  // Stimulus: directed items, then random phases at several addresses.
  initial begin
    logic [AddrWidth-1:0] phase_addr[6];
    int unsigned          target;
    in_if.valid <= 1'b0;
    in_if.op <= OP_STATUS;
    in_if.status_code <= '0;
    in_if.data_byte <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.device_address <= DefaultDeviceAddress;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Status while idle and the unused op are ignored.
    send_status(StStart, 8'h00);
    send_item(OpUnused, 8'hFF, 8'hFF);
    // Humidity read that saturates; low status bits set throughout.
    send_item(OP_READ_HUM, 8'h00, 8'h00);
    send_status(StStart | ~StatusMask, 8'h00);
    send_status(StMtSlaAck | ~StatusMask, 8'h00);
    send_status(StMtDataAck | ~StatusMask, 8'h00);
    send_status(StRepStart | ~StatusMask, 8'h00);
    send_status(StMrSlaAck | ~StatusMask, 8'h00);
    send_status(StMrDataAck | ~StatusMask, 8'hFF);
    send_status(StMrDataNack | ~StatusMask, 8'hF0);
    // Temperature read reusing the humidity measurement, with a command while
    // busy, a repeated start as first status and the lowest raw value.
    send_item(OP_READ_TEMP, 8'hFF, 8'hFF);
    send_status(StRepStart, 8'hFF);
    send_status(StMtSlaAck, 8'hFF);
    send_item(OP_READ_HUM, 8'h00, 8'h00);
    send_status(StMtDataAck, 8'hFF);
    send_status(StRepStart, 8'hFF);
    send_status(StMrSlaAck, 8'hFF);
    send_status(StMrDataAck, 8'h00);
    send_status(StMrDataNack, 8'h00);
    // Failed first start gives no stop and drops the humidity result.
    send_item(OP_READ_HUM, 8'h00, 8'h00);
    send_status(8'h00, 8'h00);
    // Wrong acknowledge after the address gives a stop.
    send_item(OP_READ_TEMP, 8'h00, 8'h00);
    send_status(StStart, 8'h00);
    send_status(StMtDataAck, 8'h00);

    phase_addr[0] = 7'h00;
    phase_addr[1] = 7'h7F;
    phase_addr[2] = AddrWidth'($urandom_range(0, 127));
    phase_addr[3] = DefaultDeviceAddress;
    phase_addr[4] = AddrWidth'($urandom_range(0, 127));
    phase_addr[5] = AddrWidth'($urandom_range(0, 127));
    for (int p = 0; p < 6; p++) begin
      // Abort any read still open so the address changes between reads.
      send_status(StBogus, 8'h00);
      drain();
      write_address(phase_addr[p]);
      quiet_phase = (p == 2);
      target = 24 + (NumItems - 24) * (p + 1) / 6;
      while (items_sent < target) begin
        if ($urandom_range(0, 3) != 0) begin
          run_read();
        end else begin
          send_item(OpWidth'($urandom_range(0, 3)), ByteWidth'($urandom_range(0, 255)),
                    ByteWidth'($urandom_range(0, 255)));
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #(20_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
